### hw/rtl/prf_pkg.sv
`default_nettype none

package prf_pkg;

    // recency ranks saturate at this value
    localparam int RANK_W = 3;
    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    // fault counter width and saturation value
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;

    // replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // reset value of the frame count
    localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 4'd3;

    // fixed port widths
    localparam int PAGE_PORT_W  = 4;
    localparam int FRAME_PORT_W = 3;

endpackage

`default_nettype wire

### hw/rtl/page_replacement_fifo_lru.sv
// page_replacement_fifo_lru: fifo / lru page replacement over a small frame set
// an accepted input beat is captured in the input register; its result is then loaded into the result register
// throughput: one page reference per cycle unless out_ready stalls the result register; the
//   combinational frame compare and state update between the input register and the result register sets this
// reset (rst_n, async, active low): all frames empty, ranks, fifo pointer and
//   fault count cleared, policy fifo, three frames in use
`default_nettype none

module page_replacement_fifo_lru
    import prf_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_COUNT = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // configuration write port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,

    // page reference channel
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [PAGE_PORT_W-1:0]   page,

    // result channel
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          fault,
    output logic [FRAME_PORT_W-1:0]       frame_used,
    output logic                          evicted_valid,
    output logic [PAGE_PORT_W-1:0]        evicted_page,
    output logic [COUNT_W-1:0]            fault_total
);

    // frame index width, at least one bit even for a single frame
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    // stored page width: pages are reduced modulo PAGE_COUNT but never exceed the port
    localparam int PAGE_W = (PAGE_COUNT >= 16) ? PAGE_PORT_W : $clog2(PAGE_COUNT);
    localparam logic [8:0] PAGE_MOD = 9'(PAGE_COUNT);
    localparam logic [4:0] FRAMES_MAX = 5'(MAX_FRAMES);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                  policy_reg;
    logic [CFG_DATA_W-1:0] frames_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_data[0];
                CFG_FRAMES: frames_reg <= cfg_data;
                default:    ; // unmapped index, write dropped
            endcase
        end
    end

    // effective frame count, clamped to 1..MAX_FRAMES
    logic [4:0] n_eff;

    always_comb
    begin
        if (frames_reg == '0)
            n_eff = 5'd1;
        else if ({1'b0, frames_reg} > FRAMES_MAX)
            n_eff = FRAMES_MAX;
        else
            n_eff = {1'b0, frames_reg};
    end

    // ------------------------------------------------------------------
    // input stage: page reduced modulo PAGE_COUNT on capture
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [PAGE_W-1:0] s1_page_reg;
    logic [PAGE_W-1:0] page_mod;
    logic [8:0]        page_rem;
    logic              advance;

    // repeated subtract; 15 / 2 needs at most seven steps
    always_comb
    begin
        page_rem = {5'b0, page};
        for (int k = 0; k < 8; k++)
        begin
            if (page_rem >= PAGE_MOD)
                page_rem = page_rem - PAGE_MOD;
        end
        page_mod = page_rem[PAGE_W-1:0];
    end

    logic out_valid_reg;
    logic out_valid_next;

    // the work stage moves when the result register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_page_reg <= page_mod;
    end

    // ------------------------------------------------------------------
    // frame state
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0]      frame_page_reg  [MAX_FRAMES];
    logic [PAGE_W-1:0]      frame_page_next [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  frame_valid_reg;
    logic [MAX_FRAMES-1:0]  frame_valid_next;
    logic [RANK_W-1:0]      rank_reg  [MAX_FRAMES];
    logic [RANK_W-1:0]      rank_next [MAX_FRAMES];
    logic [FW-1:0]          fifo_ptr_reg;
    logic [FW-1:0]          fifo_ptr_next;
    logic [COUNT_W-1:0]     fault_cnt_reg;
    logic [COUNT_W-1:0]     fault_cnt_next;

    // ------------------------------------------------------------------
    // lookup: hit, first empty frame, fifo victim and lru victim
    // ------------------------------------------------------------------
    logic [MAX_FRAMES-1:0]  active;
    logic [MAX_FRAMES-1:0]  lru_win;
    logic                   hit;
    logic [FW-1:0]          hit_idx;
    logic                   has_empty;
    logic [FW-1:0]          empty_idx;
    logic [FW-1:0]          fifo_idx;
    logic [FW-1:0]          lru_idx;
    logic                   lru_found;
    logic [4:0]             fifo_inc;

    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        has_empty = 1'b0;
        empty_idx = '0;
        for (int g = 0; g < MAX_FRAMES; g++)
        begin
            active[g] = (5'(g) < n_eff);
            if (active[g] && frame_valid_reg[g] && frame_page_reg[g] == s1_page_reg && !hit)
            begin
                hit     = 1'b1;
                hit_idx = FW'(g);
            end
            if (active[g] && !frame_valid_reg[g] && !has_empty)
            begin
                has_empty = 1'b1;
                empty_idx = FW'(g);
            end
        end
    end

    // lru: a frame wins if it beats every lower frame and ties or beats every higher one,
    // so the first frame holding the largest rank wins
    always_comb
    begin
        for (int f = 0; f < MAX_FRAMES; f++)
        begin
            lru_win[f] = active[f];
            for (int g = 0; g < MAX_FRAMES; g++)
            begin
                if (active[g] && g < f && !(rank_reg[g] < rank_reg[f]))
                    lru_win[f] = 1'b0;
                if (active[g] && g > f && !(rank_reg[g] <= rank_reg[f]))
                    lru_win[f] = 1'b0;
            end
        end
        lru_found = 1'b0;
        lru_idx   = '0;
        for (int f = 0; f < MAX_FRAMES; f++)
        begin
            if (lru_win[f] && !lru_found)
            begin
                lru_found = 1'b1;
                lru_idx   = FW'(f);
            end
        end
    end

    // fifo: a stale pointer beyond the frame count restarts at frame 0
    always_comb
    begin
        fifo_idx = (5'(fifo_ptr_reg) < n_eff) ? fifo_ptr_reg : '0;
        fifo_inc = 5'(fifo_idx) + 5'd1;
    end

    // ------------------------------------------------------------------
    // decision and state update
    // ------------------------------------------------------------------
    logic              filled;
    logic              evicting;
    logic [FW-1:0]     used;
    logic [RANK_W-1:0] rank_used;
    logic [PAGE_W-1:0] ev_page;
    logic [4:0]        used_wide;

    always_comb
    begin
        filled   = 1'b0;
        evicting = 1'b0;
        priority if (hit)
            used = hit_idx;
        else if (has_empty)
        begin
            used   = empty_idx;
            filled = 1'b1;
        end
        else if (policy_reg == POLICY_FIFO)
        begin
            used     = fifo_idx;
            evicting = 1'b1;
        end
        else
        begin
            used     = lru_idx;
            evicting = 1'b1;
        end

        rank_used = rank_reg[used];
        ev_page   = evicting ? frame_page_reg[used] : '0;
        used_wide = 5'(used);
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        fifo_ptr_next    = fifo_ptr_reg;
        fault_cnt_next   = fault_cnt_reg;
        for (int g = 0; g < MAX_FRAMES; g++)
        begin
            frame_page_next[g] = frame_page_reg[g];
            rank_next[g]       = rank_reg[g];
        end

        if (advance)
        begin
            if (!hit)
            begin
                frame_page_next[used] = s1_page_reg;
                frame_valid_next[used] = 1'b1;
                if (fault_cnt_reg != COUNT_MAX)
                    fault_cnt_next = fault_cnt_reg + 1'b1;
            end
            if (evicting && policy_reg == POLICY_FIFO)
                fifo_ptr_next = (fifo_inc < n_eff) ? FW'(fifo_inc) : '0;

            // touched frame goes to rank 0; valid frames ranked below it age by one, all valid frames on a fill
            for (int g = 0; g < MAX_FRAMES; g++)
            begin
                if (FW'(g) == used)
                    rank_next[g] = '0;
                else if (active[g] && frame_valid_reg[g]
                         && (filled || rank_reg[g] < rank_used)
                         && rank_reg[g] != RANK_MAX)
                    rank_next[g] = rank_reg[g] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_valid_reg <= '0;
            fifo_ptr_reg    <= '0;
            fault_cnt_reg   <= '0;
            for (int g = 0; g < MAX_FRAMES; g++)
            begin
                frame_page_reg[g] <= '0;
                rank_reg[g]       <= '0;
            end
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            frame_valid_reg <= frame_valid_next;
            fifo_ptr_reg    <= fifo_ptr_next;
            fault_cnt_reg   <= fault_cnt_next;
            for (int g = 0; g < MAX_FRAMES; g++)
            begin
                frame_page_reg[g] <= frame_page_next[g];
                rank_reg[g]       <= rank_next[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                    fault_reg;
    logic [FRAME_PORT_W-1:0] frame_used_reg;
    logic                    ev_valid_reg;
    logic [PAGE_PORT_W-1:0]  ev_page_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_reg      <= !hit;
            frame_used_reg <= used_wide[FRAME_PORT_W-1:0];
            ev_valid_reg   <= evicting;
            ev_page_reg    <= PAGE_PORT_W'(ev_page);
        end
    end

    assign out_valid     = out_valid_reg;
    assign fault         = fault_reg;
    assign frame_used    = frame_used_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    // the count only moves when a result is loaded, so it always matches the held beat
    assign fault_total   = fault_cnt_reg;

endmodule

`default_nettype wire

### dv/page_replacement_fifo_lru_test.sv
`timescale 1ns / 100ps

module page_replacement_fifo_lru_test;
    import prf_pkg::*;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_COUNT = 16;

    // cycles with no beat on either channel before the run is called hung
    localparam int IDLE_LIMIT = 1000;

    // mismatch lines shown before going quiet
    localparam int SHOWN_MAX = 40;

    // indexes past the register map, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // one result beat as it should leave the block
    typedef struct packed {
        logic                    fault;
        logic [FRAME_PORT_W-1:0] frame;
        logic                    ev_valid;
        logic [PAGE_PORT_W-1:0]  ev_page;
        logic [COUNT_W-1:0]      total;
    } ref_result_t;

    // ------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [PAGE_PORT_W-1:0]  page = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    fault;
    logic [FRAME_PORT_W-1:0] frame_used;
    logic                    evicted_valid;
    logic [PAGE_PORT_W-1:0]  evicted_page;
    logic [COUNT_W-1:0]      fault_total;

    // idling knobs: percent chance of a random-length idle burst, per sent beat and per result-side check
    int gap_odds = 20;
    int stall_odds = 20;
    bit calm = 1'b0;

    int mismatches = 0;
    int idle_cycles = 0;

    // outcomes of accepted references, oldest first
    ref_result_t predicted_outcomes[$];

    // ------------------------------------------------------------------
    // shadow of the replacement state
    // ------------------------------------------------------------------
    logic [PAGE_PORT_W-1:0] frame_tag [MAX_FRAMES];
    logic                   frame_full [MAX_FRAMES];
    logic [RANK_W-1:0]      frame_age [MAX_FRAMES];
    int                     fifo_next;
    logic [COUNT_W-1:0]     faults_seen;
    logic                   model_policy;
    logic [CFG_DATA_W-1:0]  model_frames;

    page_replacement_fifo_lru #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page          (page),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fault         (fault),
        .frame_used    (frame_used),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // frame f becomes most recent; valid neighbours ranked below it age by one,
    // or every valid neighbour ages when f was just filled
    function automatic void refresh_age(input int f, input int n, input bit filled);
        int g;
        for (g = 0; g < n; g++)
        begin
            if (g != f && frame_full[g] && (filled || frame_age[g] < frame_age[f])
                    && frame_age[g] != RANK_MAX)
                frame_age[g]++;
        end
        frame_age[f] = '0;
    endfunction

    function automatic ref_result_t replace_page(input logic [PAGE_PORT_W-1:0] pg);
        ref_result_t res;
        int n;
        int hit_f;
        int empty_f;
        int used;
        int g;
        res = '0;
        // out-of-range frame counts clamp to 1..MAX_FRAMES
        if (model_frames == 0)
            n = 1;
        else if (model_frames > MAX_FRAMES)
            n = MAX_FRAMES;
        else
            n = int'(model_frames);
        hit_f = -1;
        empty_f = -1;
        // lowest matching frame wins, frames past the count are invisible
        for (g = 0; g < n; g++)
        begin
            if (hit_f < 0 && frame_full[g] && frame_tag[g] == pg)
                hit_f = g;
            if (empty_f < 0 && !frame_full[g])
                empty_f = g;
        end
        if (hit_f >= 0)
        begin
            used = hit_f;
            refresh_age(used, n, 1'b0);
        end
        else
        begin
            res.fault = 1'b1;
            if (empty_f >= 0)
            begin
                used = empty_f;
                frame_full[used] = 1'b1;
                frame_tag[used] = pg;
                refresh_age(used, n, 1'b1);
            end
            else
            begin
                if (model_policy == POLICY_FIFO)
                begin
                    // a stale pointer past the count restarts at frame 0
                    used = (fifo_next < n) ? fifo_next : 0;
                    fifo_next = (used + 1 < n) ? used + 1 : 0;
                end
                else
                begin
                    // oldest rank, lowest index on a tie
                    used = 0;
                    for (g = 1; g < n; g++)
                    begin
                        if (frame_age[g] > frame_age[used])
                            used = g;
                    end
                end
                res.ev_valid = 1'b1;
                res.ev_page = frame_tag[used];
                frame_tag[used] = pg;
                refresh_age(used, n, 1'b0);
            end
            if (faults_seen != COUNT_MAX)
                faults_seen++;
        end
        res.frame = FRAME_PORT_W'(used);
        res.total = faults_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a rising edge
    // ------------------------------------------------------------------

    // one page reference beat, with an occasional gap in front
    task automatic send_ref(input logic [PAGE_PORT_W-1:0] pg);
        if (!calm && $urandom_range(1, 100) <= gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        page <= pg;
        do @(posedge clk); while (!in_ready);
        predicted_outcomes.push_back(replace_page(pg));
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_we high; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_POLICY)
            model_policy = val[0];
        else if (idx == CFG_FRAMES)
            model_frames = val;
    endtask

    // new setting once the block is idle; the spare write lands in between
    task automatic reconfigure(input logic pol, input logic [CFG_DATA_W-1:0] frames,
                               input logic [CFG_IDX_W-1:0] spare_idx,
                               input logic [CFG_DATA_W-1:0] spare_val);
        wait_drained();
        // upper policy bits are noise the block should drop
        write_reg(CFG_POLICY, {(CFG_DATA_W-1)'($urandom), pol});
        write_reg(spare_idx, spare_val);
        write_reg(CFG_FRAMES, frames);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset setting: fifo over three frames, fills, two hits and two evictions
    task automatic test_fifo_basics();
        send_ref(4'd0);
        send_ref(4'd15);
        send_ref(4'd7);
        send_ref(4'd15);
        send_ref(4'd4);
        send_ref(4'd0);
        send_ref(4'd7);
    endtask

    // lru on the frames fifo left behind, so ranks decide the victim
    task automatic test_lru_order();
        reconfigure(POLICY_LRU, 4'd3, CFG_SPARE_LO, 4'hF);
        send_ref(4'd4);
        send_ref(4'd9);
        send_ref(4'd0);
        send_ref(4'd4);
        send_ref(4'd3);
    endtask

    // count above the frame array, a zero count with a stale fifo pointer,
    // then a duplicate page seen from a wider window
    task automatic test_frame_count_edges();
        reconfigure(POLICY_LRU, 4'd15, CFG_SPARE_HI, 4'h0);
        send_ref(4'd1);
        send_ref(4'd2);
        send_ref(4'd3);
        send_ref(4'd4);
        send_ref(4'd5);
        // only frame 0 visible; page 5 also sits in frame 5
        reconfigure(POLICY_FIFO, 4'd0, CFG_SPARE_LO, 4'h5);
        send_ref(4'd5);
        reconfigure(POLICY_FIFO, 4'd8, CFG_SPARE_HI, 4'hA);
        send_ref(4'd5);
        send_ref(4'd6);
    endtask

    // phases of fixed then random settings, mostly pages from a small random working set
    task automatic test_random_traffic();
        int phase;
        int beat;
        int ws;
        int base;
        logic pol;
        logic [CFG_DATA_W-1:0] frames;
        logic [PAGE_PORT_W-1:0] pg;
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:       frames = 4'd1;
                1:       frames = 4'd8;
                2:       frames = 4'd12;
                default:
                    case ($urandom_range(0, 5))
                        0:       frames = 4'd0;
                        1:       frames = 4'd1;
                        2:       frames = 4'd8;
                        3:       frames = CFG_DATA_W'($urandom_range(9, 15));
                        default: frames = CFG_DATA_W'($urandom_range(2, 7));
                    endcase
            endcase
            pol = (phase < 2) ? phase[0] : 1'($urandom);
            reconfigure(pol, frames, $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                        CFG_DATA_W'($urandom));
            // some phases run flat out on one or both sides
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 5;
                default: gap_odds = 30;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 5;
                default: stall_odds = 30;
            endcase
            ws = $urandom_range(1, 11);
            base = $urandom_range(0, PAGE_COUNT - 1);
            for (beat = 0; beat < 60; beat++)
            begin
                // sender pauses mid-phase until the pipe is empty
                if (beat == 30 && phase % 3 == 1)
                    wait_drained();
                if ($urandom_range(0, 9) < 8)
                    pg = PAGE_PORT_W'(base + $urandom_range(0, ws - 1));
                else
                    pg = PAGE_PORT_W'($urandom);
                send_ref(pg);
            end
        end
    endtask

    // one frame, with the page switched after each fault: a fault evicts the
    // page before it, back to back with no idling on either side
    task automatic test_fault_streak();
        calm = 1'b1;
        reconfigure(POLICY_FIFO, 4'd1, CFG_SPARE_HI, CFG_DATA_W'($urandom));
        repeat (20) send_ref(faults_seen[0] ? 4'd3 : 4'd12);
    endtask

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_tag[i] = '0;
            frame_full[i] = 1'b0;
            frame_age[i] = '0;
        end
        fifo_next = 0;
        faults_seen = '0;
        model_policy = POLICY_FIFO;
        model_frames = FRAMES_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_fifo_basics();
        test_lru_order();
        test_frame_count_edges();
        test_random_traffic();
        test_fault_streak();

        wait_drained();
        // tail: catch any stray beat after the last expected one
        repeat (4) @(posedge clk);
        if (mismatches == 0 && predicted_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random backpressure in bursts, none once calm
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(1, 100) <= stall_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // each result beat against the oldest prediction
    always @(posedge clk)
    begin : result_check
        ref_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("%0t: result beat with nothing expected, got frame %0d fault %b",
                             $time, frame_used, fault);
            end
            else
            begin
                want = predicted_outcomes.pop_front();
                check_field("fault", COUNT_W'(want.fault), COUNT_W'(fault));
                check_field("frame_used", COUNT_W'(want.frame), COUNT_W'(frame_used));
                check_field("evicted_valid", COUNT_W'(want.ev_valid), COUNT_W'(evicted_valid));
                check_field("evicted_page", COUNT_W'(want.ev_page), COUNT_W'(evicted_page));
                check_field("fault_total", want.total, fault_total);
            end
        end
    end

    // watchdog: too long without a beat on either side means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
